// File: sv/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg
// shared types and constants of the compact list search and remove core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clsr_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int MAX_RES   = 16;
	localparam int DATA_W    = 32;

	typedef enum logic [1:0] {
		FN_APPEND = 2'd0,
		FN_SEARCH = 2'd1,
		FN_REMOVE = 2'd2,
		FN_DUMP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NOTFOUND = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_CMP,
		CELL_SHIFT,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [DATA_W-1:0] key;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_DUMP
	} state_t;

endpackage

// File: sv/clsr_cell.sv
// ----------------------------------------------------------------------------
// clsr_cell
// one list slot: holds an entry, compares it with a key and takes the value
// of its upper neighbor on a shift, and that value or, in the last used slot, the first entry on a rotation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clsr_cell #(
	parameter int DEPTH = clsr_pkg::DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  clsr_pkg::cell_ctrl_t              ctrl,
	input  logic [$clog2(DEPTH+1)-1:0]        cnt,
	input  logic [$clog2(DEPTH)-1:0]          sel,
	input  logic [clsr_pkg::DATA_W-1:0]       next_value,
	input  logic [clsr_pkg::DATA_W-1:0]       first_value,
	output logic [clsr_pkg::DATA_W-1:0]       value,
	output logic                              match
);
	import clsr_pkg::*;

	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] POS = CW'(IDX);
	localparam logic [CW-1:0] NXT = CW'(IDX + 1);

	logic [DATA_W-1:0] value_q;
	logic              match_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_LOAD: begin
				if (cnt == POS) value_q <= ctrl.key;
			end
			CELL_SHIFT: begin
				if ((POS >= CW'(sel)) && (NXT < cnt)) value_q <= next_value;
			end
			CELL_ROT: begin
				if (NXT < cnt) value_q <= next_value;
				else if (NXT == cnt) value_q <= first_value;
			end
			CELL_HOLD, CELL_CMP: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.op == CELL_CMP) begin
			match_q <= (POS < cnt) && (value_q == ctrl.key);
		end
	end

	assign value = value_q;
	assign match = match_q;

endmodule

// File: sv/compact_list_search_remove_core.sv
// ----------------------------------------------------------------------------
// compact_list_search_remove_core
// ordered list of signed words in a row of cells with append, search,
// remove first match and dump
// append: loads the next free cell unless full; search and remove: parallel compare,
// then first-match encode and, on remove, a one-step shift of the cell row
// dump: one result per cycle as the row rotates, unless the output is stalled;
// an empty dump returns only an empty status
// one transaction in work at a time; a waiting result blocks accept until taken
// reset clears the entry count and control; entries are not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module compact_list_search_remove_core #(
	parameter int DEPTH = clsr_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // operand_value[31:0]
	input  logic [1:0]  s_axis_tuser,   // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // status[1:0] position[5:2]
	                                    // element_value[37:6] entry_count[42:38]
	output logic        m_axis_tlast    // last
);
	import clsr_pkg::*;

	localparam int CW = $clog2(DEPTH+1);
	localparam int IW = $clog2(DEPTH);

	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     k_q, k_d;
	func_t             fn_q;
	cell_ctrl_t        ctrl;

	logic [DATA_W-1:0] vals [DEPTH];
	logic [DEPTH-1:0]  match;
	logic              found;
	logic [IW-1:0]     first_idx;

	logic              ov_q;
	logic [1:0]        o_stat_q;
	logic [3:0]        o_pos_q;
	logic [DATA_W-1:0] o_val_q;
	logic [4:0]        o_cnt_q;
	logic              o_last_q;

	logic              out_free;
	logic              emit;
	status_t           e_stat;
	logic [3:0]        e_pos;
	logic [DATA_W-1:0] e_val;
	logic              e_last;

	assign out_free      = !ov_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_W-1:0] nxt;
		if (g == DEPTH - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = vals[g+1];
		end
		clsr_cell #(
			.DEPTH (DEPTH),
			.IDX   (g)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.cnt         (cnt_q),
			.sel         (first_idx),
			.next_value  (nxt),
			.first_value (vals[0]),
			.value       (vals[g]),
			.match       (match[g])
		);
	end

	// first match
	always_comb begin
		found     = 1'b0;
		first_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				found     = 1'b1;
				first_idx = IW'(i);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		k_d      = k_q;
		ctrl.op  = CELL_HOLD;
		ctrl.key = s_axis_tdata;
		emit     = 1'b0;
		e_stat   = STAT_OK;
		e_pos    = '0;
		e_val    = '0;
		e_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid && out_free) begin
					unique case (func_t'(s_axis_tuser))
						FN_APPEND: begin
							emit = 1'b1;
							if (cnt_q >= CW'(DEPTH)) begin
								e_stat = STAT_FULL;
							end else begin
								ctrl.op = CELL_LOAD;
								cnt_d   = cnt_q + 1'b1;
								e_pos   = 4'(cnt_q);
							end
						end
						FN_SEARCH, FN_REMOVE: begin
							ctrl.op = CELL_CMP;
							state_d = ST_FIND;
						end
						FN_DUMP: begin
							if (cnt_q == '0) begin
								emit   = 1'b1;
								e_stat = STAT_EMPTY;
							end else begin
								k_d     = '0;
								state_d = ST_DUMP;
							end
						end
					endcase
				end
			end
			ST_FIND: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
				if (!found) begin
					e_stat = STAT_NOTFOUND;
				end else begin
					e_pos = 4'(first_idx);
					if (fn_q == FN_REMOVE) begin
						ctrl.op = CELL_SHIFT;
						cnt_d   = cnt_q - 1'b1;
					end
				end
			end
			ST_DUMP: begin
				if ((32'(k_q) >= MAX_RES) || out_free) begin
					ctrl.op = CELL_ROT;
					k_d     = k_q + 1'b1;
					if (32'(k_q) < MAX_RES) begin
						emit   = 1'b1;
						e_pos  = 4'(k_q);
						e_val  = vals[0];
						e_last = (k_q + 1'b1 == cnt_q) || (32'(k_q) + 1 == MAX_RES);
					end
					if (k_q + 1'b1 == cnt_q) state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			fn_q    <= FN_APPEND;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
			if (s_axis_tvalid && s_axis_tready) fn_q <= func_t'(s_axis_tuser);
			if (emit) ov_q <= 1'b1;
			else if (m_axis_tready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			o_stat_q <= e_stat;
			o_pos_q  <= e_pos;
			o_val_q  <= e_val;
			o_cnt_q  <= 5'(cnt_d);
			o_last_q <= e_last;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {5'd0, o_cnt_q, o_val_q, o_pos_q, o_stat_q};
	assign m_axis_tlast  = o_last_q;

endmodule

// File: tb/tb_compact_list_search_remove_core.sv
// ----------------------------------------------------------------------------
// tb_compact_list_search_remove_core
// self-checking bench for the compact list core: a directed pass over empty,
// full, duplicate and extreme-value lists, then random operation mixes under
// several source and sink throttling profiles; every output transaction is
// compared against a behavioral copy of the list kept in a scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_compact_list_search_remove_core;

	import clsr_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int REPORT_MAX = 10;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;   // operand_value[31:0]
	logic [1:0]  s_axis_tuser  = FN_APPEND;   // func[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;   // status[1:0] position[5:2]
	                             // element_value[37:6] entry_count[42:38]
	logic        m_axis_tlast;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	bit          recv_hold      = 1'b0;

	typedef struct packed {
		status_t     status;
		logic [3:0]  position;
		logic [31:0] element_value;
		logic [4:0]  entry_count;
		logic        last;
	} list_result_t;

	class list_scoreboard;
		logic [31:0]  entries [DEPTH];
		int unsigned  used;
		list_result_t expected_q [$];
		int unsigned  errors;

		function list_result_t make_result(status_t st, int unsigned pos,
				logic [31:0] val, logic lst);
			list_result_t r;
			r.status        = st;
			r.position      = pos[3:0];
			r.element_value = val;
			r.entry_count   = used[4:0];
			r.last          = lst;
			return r;
		endfunction

		function int find_first(logic [31:0] key);
			for (int i = 0; i < used; i++)
				if (entries[i] == key)
					return i;
			return -1;
		endfunction

		function void note_input(func_t fn, logic [31:0] operand);
			int idx;
			int unsigned n;
			case (fn)
				FN_APPEND: begin
					if (used >= DEPTH) begin
						expected_q.push_back(make_result(STAT_FULL, 0, '0, 1'b1));
					end else begin
						entries[used] = operand;
						used++;
						expected_q.push_back(make_result(STAT_OK, used - 1, '0, 1'b1));
					end
				end
				FN_SEARCH: begin
					idx = find_first(operand);
					if (idx >= 0)
						expected_q.push_back(make_result(STAT_OK, idx, '0, 1'b1));
					else
						expected_q.push_back(make_result(STAT_NOTFOUND, 0, '0, 1'b1));
				end
				FN_REMOVE: begin
					idx = find_first(operand);
					if (idx >= 0) begin
						for (int k = idx; k + 1 < used; k++)
							entries[k] = entries[k + 1];
						used--;
						expected_q.push_back(make_result(STAT_OK, idx, '0, 1'b1));
					end else begin
						expected_q.push_back(make_result(STAT_NOTFOUND, 0, '0, 1'b1));
					end
				end
				default: begin
					if (used == 0) begin
						expected_q.push_back(make_result(STAT_EMPTY, 0, '0, 1'b1));
					end else begin
						n = (used > MAX_RES) ? MAX_RES : used;
						for (int k = 0; k < n; k++)
							expected_q.push_back(make_result(STAT_OK, k, entries[k],
								k + 1 == n));
					end
				end
			endcase
		endfunction

		function void check_result(logic [47:0] data, logic tlast);
			list_result_t got, exp;
			got.status        = status_t'(data[1:0]);
			got.position      = data[5:2];
			got.element_value = data[37:6];
			got.entry_count   = data[42:38];
			got.last          = tlast;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result: status %0d pos %0d value %0d count %0d last %0b",
						got.status, got.position, $signed(got.element_value),
						got.entry_count, got.last);
				return;
			end
			exp = expected_q.pop_front();
			if (got.status !== exp.status || got.position !== exp.position ||
					got.element_value !== exp.element_value ||
					got.entry_count !== exp.entry_count || got.last !== exp.last) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("mismatch: exp status %0d pos %0d value %0d count %0d last %0b",
						exp.status, exp.position, $signed(exp.element_value),
						exp.entry_count, exp.last);
					$display("          got status %0d pos %0d value %0d count %0d last %0b",
						got.status, got.position, $signed(got.element_value),
						got.entry_count, got.last);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	list_scoreboard sb = new;

	compact_list_search_remove_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// transaction monitor
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			sb.note_input(func_t'(s_axis_tuser), s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tlast);
	end

	task automatic send_op(func_t fn, logic [31:0] operand);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= fn;
		s_axis_tdata  <= operand;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic hold_receiver(int unsigned cycles);
		recv_hold = 1'b1;
		repeat (cycles) @(posedge clk);
		recv_hold = 1'b0;
	endtask

	function automatic logic [31:0] pick_operand();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45 && sb.used > 0)
			return sb.entries[$urandom_range(sb.used - 1)];
		if (r < 60) begin
			case ($urandom_range(5))
				0: return 32'h0000_0000;
				1: return 32'hffff_ffff;
				2: return 32'h8000_0000;
				3: return 32'h7fff_ffff;
				default: return $urandom_range(3);
			endcase
		end
		return $urandom;
	endfunction

	task automatic run_mix(int unsigned send_pct, int unsigned recv_pct,
			int unsigned count, int unsigned append_pct);
		func_t fn;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < append_pct) begin
				fn = FN_APPEND;
			end else begin
				case ($urandom_range(9))
					0, 1, 2, 3: fn = FN_SEARCH;
					4, 5, 6, 7: fn = FN_REMOVE;
					default:    fn = FN_DUMP;
				endcase
			end
			send_op(fn, pick_operand());
		end
		wait_results_drained();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners
		send_op(FN_DUMP, 32'h0);
		send_op(FN_SEARCH, 32'h5);
		send_op(FN_REMOVE, 32'h5);
		// extremes and a duplicate
		send_op(FN_APPEND, 32'h7fff_ffff);
		send_op(FN_APPEND, 32'h8000_0000);
		send_op(FN_APPEND, 32'h0000_0000);
		send_op(FN_APPEND, 32'hffff_ffff);
		send_op(FN_APPEND, 32'h7fff_ffff);
		send_op(FN_SEARCH, 32'h7fff_ffff);
		send_op(FN_REMOVE, 32'h7fff_ffff);
		send_op(FN_SEARCH, 32'h7fff_ffff);
		send_op(FN_DUMP, 32'hffff_ffff);
		// fill up, overflow, full dump
		for (int i = 0; i < DEPTH - 4; i++)
			send_op(FN_APPEND, 32'ha5a5_0000 + i);
		send_op(FN_APPEND, 32'h1234_5678);
		send_op(FN_DUMP, 32'h0);
		wait_results_drained();

		run_mix(0, 0, 20, 40);
		run_mix(88, 0, 16, 45);
		run_mix(0, 88, 16, 35);
		run_mix(25, 25, 20, 50);
		fork
			hold_receiver(200);
		join_none
		run_mix(0, 0, 12, 85);

		repeat (40) @(posedge clk);
		while (sb.pending() != 0) begin
			sb.errors++;
			void'(sb.expected_q.pop_front());
		end
		if (sb.errors == 0) begin
			$display("tb_compact_list_search_remove_core: PASS");
		end else begin
			$display("tb_compact_list_search_remove_core: FAIL");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("tb_compact_list_search_remove_core: FAIL");
		$finish;
	end

endmodule
